// File: rtl/doc_score_group_accumulator_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the document score group accumulator.
// Define ASSERT_OFF to compile every check away.
// ---------------------------------------------------------------------------
`ifndef DOC_SCORE_GROUP_ACCUMULATOR_CORE_ASSERT_SVH
`define DOC_SCORE_GROUP_ACCUMULATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define DSGA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsga assertion failed");
// Implication into the following cycle.
`define DSGA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsga assertion failed");
`else
`define DSGA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DSGA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/dsga_pkg.sv
// ---------------------------------------------------------------------------
// dsga_pkg
// Types and codes shared by the document score group accumulator.
// ---------------------------------------------------------------------------
package dsga_pkg;

    localparam logic CMD_HIT   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] doc_id;
        logic [15:0] hit_score;
        logic [31:0] expr_position;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_doc;
        logic [31:0] out_score;
        logic [4:0]  out_count;
        logic [31:0] out_position;
        logic        is_last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_APPLY
    } t_state;

endpackage

// File: rtl/dsga_pos_store.sv
// ---------------------------------------------------------------------------
// dsga_pos_store
// Position store: one write port and one registered read port.
// ---------------------------------------------------------------------------
module dsga_pos_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_data
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The read data holds between reads, so it can sit in the output register.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/doc_score_group_accumulator_core.sv
// ---------------------------------------------------------------------------
// doc_score_group_accumulator_core
// Groups consecutive hits per document, sums scores with saturation and
// emits one result per kept position when a group with a nonzero score closes.
// ---------------------------------------------------------------------------
// A transaction that closes no scoring group is accepted, then applied in the update state.
// Closing a group of n kept positions first emits each position, then applies the update;
// each position is one read of the store followed by its output transaction.
// The input is stalled from acceptance until the update cycle has completed.
// Reset is synchronous and active low; it clears the group state and the
// sequencer, and leaves the position store as it is (no clearing pass).
`include "doc_score_group_accumulator_core_assert.svh"

module doc_score_group_accumulator_core #(
    parameter int MAX_POSITIONS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  dsga_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output dsga_pkg::t_out_item o_item
);

    localparam int KW = $clog2(MAX_POSITIONS + 1);
    localparam int IW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;

    dsga_pkg::t_state   r_state;
    dsga_pkg::t_state   n_state;
    dsga_pkg::t_in_item r_item;

    logic [31:0]   r_open_doc;
    logic [31:0]   r_open_score;
    logic [KW-1:0] r_kept;
    logic [IW-1:0] r_idx;

    logic          r_out_valid;
    logic [31:0]   r_out_doc;
    logic [31:0]   r_out_score;
    logic [4:0]    r_out_count;
    logic          r_out_last;

    logic          w_accept;
    logic          w_in_emit;
    logic          w_new_doc;
    logic          w_last;
    logic          w_rd_en;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_addr;
    logic [31:0]   w_rd_data;
    logic [31:0]   w_base_score;
    logic [KW-1:0] w_base_kept;
    logic [32:0]   w_sum;
    logic [31:0]   w_count_ext;

    // A new transaction emits when it closes a group that has a score and positions.
    assign w_in_emit = ((i_item.cmd == dsga_pkg::CMD_FLUSH) || (i_item.doc_id != r_open_doc))
                       && (r_open_score != 32'd0) && (r_kept != '0);
    assign w_new_doc = (r_item.doc_id != r_open_doc);
    assign w_last    = ((KW'(r_idx) + KW'(1)) == r_kept);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dsga_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = w_in_emit ? dsga_pkg::ST_READ : dsga_pkg::ST_APPLY;
                end
            end
            dsga_pkg::ST_READ: begin
                n_state = dsga_pkg::ST_WAIT;
            end
            dsga_pkg::ST_WAIT: begin
                if (!i_stall) begin
                    n_state = r_out_last ? dsga_pkg::ST_APPLY : dsga_pkg::ST_READ;
                end
            end
            dsga_pkg::ST_APPLY: begin
                n_state = dsga_pkg::ST_IDLE;
            end
            default: begin
                n_state = dsga_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        w_accept = 1'b0;
        w_rd_en  = 1'b0;
        w_wr_en  = 1'b0;
        unique case (r_state)
            dsga_pkg::ST_IDLE:  w_accept = i_valid;
            dsga_pkg::ST_READ:  w_rd_en  = 1'b1;
            dsga_pkg::ST_WAIT:  w_accept = 1'b0;
            dsga_pkg::ST_APPLY: w_wr_en  = (r_item.cmd == dsga_pkg::CMD_HIT)
                                           && (w_base_kept < KW'(MAX_POSITIONS));
            default:            w_accept = 1'b0;
        endcase
    end

    // The shared saturating adder; a new document starts from an empty group.
    always_comb begin
        w_base_score = w_new_doc ? 32'd0 : r_open_score;
        w_base_kept  = w_new_doc ? '0 : r_kept;
        w_sum        = {1'b0, w_base_score} + 33'(r_item.hit_score);
        w_wr_addr    = w_base_kept[IW-1:0];
        w_count_ext  = 32'(r_kept);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dsga_pkg::ST_IDLE;
            r_open_doc   <= 32'd0;
            r_open_score <= 32'd0;
            r_kept       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == dsga_pkg::ST_READ) begin
                r_out_valid <= 1'b1;
            end else if ((r_state == dsga_pkg::ST_WAIT) && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == dsga_pkg::ST_APPLY) begin
                if (r_item.cmd == dsga_pkg::CMD_FLUSH) begin
                    r_open_doc   <= 32'd0;
                    r_open_score <= 32'd0;
                    r_kept       <= '0;
                end else begin
                    r_open_doc   <= r_item.doc_id;
                    r_open_score <= w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
                    r_kept       <= w_wr_en ? (w_base_kept + KW'(1)) : w_base_kept;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
            r_idx  <= '0;
        end else if ((r_state == dsga_pkg::ST_WAIT) && !i_stall && !r_out_last) begin
            r_idx <= r_idx + IW'(1);
        end
        if (r_state == dsga_pkg::ST_READ) begin
            r_out_doc   <= r_open_doc;
            r_out_score <= r_open_score;
            r_out_count <= w_count_ext[4:0];
            r_out_last  <= w_last;
        end
    end

    dsga_pos_store #(
        .DEPTH (MAX_POSITIONS),
        .AW    (IW)
    ) u_pos_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_item.expr_position),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    assign o_stall              = (r_state != dsga_pkg::ST_IDLE);
    assign o_valid              = r_out_valid;
    assign o_item.out_doc       = r_out_doc;
    assign o_item.out_score     = r_out_score;
    assign o_item.out_count     = r_out_count;
    assign o_item.out_position  = w_rd_data;
    assign o_item.is_last       = r_out_last;

    `DSGA_ASSERT_IMP(a_valid_in_wait, i_clk, i_rst_n, o_valid, r_state == dsga_pkg::ST_WAIT)
    `DSGA_ASSERT_NXT(a_accept_moves_on, i_clk, i_rst_n, i_valid && !o_stall,
                     r_state == dsga_pkg::ST_READ || r_state == dsga_pkg::ST_APPLY)
    `DSGA_ASSERT_IMP(a_read_has_group, i_clk, i_rst_n, r_state == dsga_pkg::ST_READ,
                     r_open_score != 32'd0 && KW'(r_idx) < r_kept)
    `DSGA_ASSERT_IMP(a_kept_bounded, i_clk, i_rst_n, 1'b1, r_kept <= KW'(MAX_POSITIONS))
    `DSGA_ASSERT_NXT(a_group_held_while_emitting, i_clk, i_rst_n,
                     r_state == dsga_pkg::ST_WAIT && !i_stall && !r_out_last,
                     $stable(r_open_doc) && $stable(r_kept))

endmodule

// File: test/doc_score_group_accumulator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// doc_score_group_accumulator_core_tb
// Drives expression hits and flushes into the group accumulator and checks
// every position result against an in-bench prediction of the grouping,
// saturating score sum and position keeping, with random idling on both
// sides of the block.
// ----------------------------------------------------------------------------
module doc_score_group_accumulator_core_tb;

    localparam int KEEP_LIMIT = 16;
    localparam int RANDOM_HITS = 400;
    localparam int LONG_RUN_HITS = 40;

    // Mirrors the grouping of the block and holds the position results that
    // are still to arrive.
    class group_ledger;
        logic [31:0]         cur_doc = '0;
        logic [31:0]         cur_score = '0;
        int unsigned         kept = 0;
        logic [31:0]         kept_pos [KEEP_LIMIT];
        dsga_pkg::t_out_item expected_q [$];
        int unsigned         failures = 0;

        function void report(string what, dsga_pkg::t_out_item exp_item,
                             dsga_pkg::t_out_item got);
            failures++;
            if (failures <= 10) begin
                $display("%0t: %s: expected doc %h score %h count %0d pos %h last %b",
                         $realtime, what, exp_item.out_doc, exp_item.out_score,
                         exp_item.out_count, exp_item.out_position, exp_item.is_last);
                $display("%0t: %s: actual   doc %h score %h count %0d pos %h last %b",
                         $realtime, what, got.out_doc, got.out_score,
                         got.out_count, got.out_position, got.is_last);
            end
        endfunction

        function void close_group();
            dsga_pkg::t_out_item r;
            if (cur_score != 0 && kept != 0) begin
                for (int k = 0; k < kept; k++) begin
                    r.out_doc      = cur_doc;
                    r.out_score    = cur_score;
                    r.out_count    = 5'(kept);
                    r.out_position = kept_pos[k];
                    r.is_last      = (k + 1 == kept);
                    expected_q.push_back(r);
                end
            end
        endfunction

        function void note_item(dsga_pkg::t_in_item it);
            logic [32:0] sum;
            if (it.cmd == dsga_pkg::CMD_FLUSH) begin
                close_group();
                cur_doc = '0;
                cur_score = '0;
                kept = 0;
                return;
            end
            if (it.doc_id != cur_doc) begin
                close_group();
                cur_doc = it.doc_id;
                cur_score = '0;
                kept = 0;
            end
            sum = {1'b0, cur_score} + {17'b0, it.hit_score};
            cur_score = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (kept < KEEP_LIMIT) begin
                kept_pos[kept] = it.expr_position;
                kept++;
            end
        endfunction

        function void check_result(dsga_pkg::t_out_item got);
            dsga_pkg::t_out_item exp_item;
            if (expected_q.size() == 0) begin
                report("unexpected result", '0, got);
                return;
            end
            exp_item = expected_q.pop_front();
            if (got.out_doc !== exp_item.out_doc || got.out_score !== exp_item.out_score ||
                got.out_count !== exp_item.out_count ||
                got.out_position !== exp_item.out_position ||
                got.is_last !== exp_item.is_last)
                report("result mismatch", exp_item, got);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    dsga_pkg::t_in_item  i_item = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    dsga_pkg::t_out_item o_item;

    group_ledger ledger = new();
    // While set, neither side idles.
    bit quiet = 1'b0;

    doc_score_group_accumulator_core #(
        .MAX_POSITIONS(KEEP_LIMIT)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_item (o_item)
    );

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        return quiet ? 0 : int'($urandom_range(0, 4));
    endfunction

    function automatic dsga_pkg::t_in_item make_item(logic cmd, logic [31:0] doc,
                                                     logic [15:0] score,
                                                     logic [31:0] pos);
        dsga_pkg::t_in_item it;
        it.cmd = cmd;
        it.doc_id = doc;
        it.hit_score = score;
        it.expr_position = pos;
        return it;
    endfunction

    // Called at a rising edge; returns at the edge that accepts the transaction.
    task automatic send_item(dsga_pkg::t_in_item it);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        do @(negedge i_clk); while (o_stall !== 1'b0);
        ledger.note_item(it);
        @(posedge i_clk);
    endtask

    task automatic send_hit(logic [31:0] doc, logic [15:0] score, logic [31:0] pos);
        send_item(make_item(dsga_pkg::CMD_HIT, doc, score, pos));
    endtask

    // Result side: stall for a random gap before each transaction, and never while quiet.
    initial begin
        int hold;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = pick_gap();
            repeat (hold) begin
                i_stall <= 1'b1;
                @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(negedge i_clk); while (o_valid !== 1'b1);
            ledger.check_result(o_item);
            @(posedge i_clk);
        end
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int sent;
        int run_len;
        logic [31:0] doc;
        logic [15:0] score;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: document 0 after reset, field extremes, zero-score groups,
        // flushes with junk fields and a flush with nothing open.
        send_hit(32'h0, 16'h0005, 32'hFFFF_FFFF);
        send_hit(32'h0, 16'hFFFF, 32'h0);
        send_hit(32'hFFFF_FFFF, 16'h0, 32'h1234_5678);
        send_hit(32'hFFFF_FFFF, 16'h0, 32'h1);
        send_hit(32'h1, 16'h0003, 32'h2);
        send_item(make_item(dsga_pkg::CMD_FLUSH, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(make_item(dsga_pkg::CMD_FLUSH, 32'h0, 16'h0, 32'h0));
        send_hit(32'h0, 16'h0, 32'hAAAA_AAAA);
        send_item(make_item(dsga_pkg::CMD_FLUSH, 32'h5555_5555, 16'h5555, 32'h5555_5555));
        send_hit(32'h0, 16'h0001, 32'h5555_5555);
        send_hit(32'h8000_0000, 16'h8000, 32'h8000_0000);
        send_item(make_item(dsga_pkg::CMD_FLUSH, 32'h0, 16'h0, 32'h0));
        for (int k = 0; k < 10; k++)
            send_hit(32'h0000_0007, 16'h0001, 32'h100 + k);

        // Long group of maximal scores: positions beyond the limit are dropped
        // while their scores still count.
        quiet = 1'b1;
        for (int k = 0; k < LONG_RUN_HITS; k++)
            send_hit(32'h5A5A_0001, 16'hFFFF, 32'(k));
        send_item(make_item(dsga_pkg::CMD_FLUSH, $urandom, 16'($urandom), $urandom));
        quiet = 1'b0;

        // Random groups of consecutive hits, with stray flushes as noise.
        sent = 0;
        while (sent < RANDOM_HITS) begin
            if ($urandom_range(0, 5) == 0)
                quiet = ~quiet;
            if ($urandom_range(0, 9) == 0)
                send_item(make_item(dsga_pkg::CMD_FLUSH, $urandom, 16'($urandom), $urandom));
            case ($urandom_range(0, 7))
                0: doc = 32'h0;
                1: doc = 32'hFFFF_FFFF;
                2: doc = 32'($urandom_range(0, 3));
                default: doc = $urandom;
            endcase
            run_len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(14, 20))
                                                    : int'($urandom_range(1, 4));
            for (int k = 0; k < run_len; k++) begin
                case ($urandom_range(0, 15))
                    0, 1: score = 16'h0;
                    2: score = 16'hFFFF;
                    default: score = 16'($urandom);
                endcase
                send_hit(doc, score, $urandom);
                sent++;
            end
        end
        send_item(make_item(dsga_pkg::CMD_FLUSH, $urandom, 16'($urandom), $urandom));
        i_valid <= 1'b0;
        quiet = 1'b0;

        while (ledger.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (ledger.failures == 0 && ledger.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
